// ===== sv/b64d_pkg.sv =====
// Shared types and constants for the base64 decoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

  // Default number of decode jobs held between front and back
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned SextetW = 6;
  localparam int unsigned StoreW  = 3 * SextetW;
  localparam int unsigned GroupW  = 4 * SextetW;

  // Byte count codes for one job
  localparam logic [1:0] NBytesOne   = 2'd1;
  localparam logic [1:0] NBytesTwo   = 2'd2;
  localparam logic [1:0] NBytesThree = 2'd3;

  // One unit of work for the back end: up to three bytes from one character
  typedef struct packed {
    logic [GroupW-1:0] word;
    logic [1:0]        nbytes;
    logic              no_data;
    logic              last;
  } job_t;

endpackage

// ===== sv/b64d_front.sv =====
// Front end: accepts characters, classifies them and tracks the sextet group.
// Pushes one job per character that releases bytes or closes the text. Uses b64d_pkg.
`timescale 1ns / 1ps

module b64d_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               queue_full_i,
  input  logic [7:0]         char_code_i,
  input  logic               end_of_text_i,
  output logic               in_stall_o,
  output logic               push_o,
  output b64d_pkg::job_t     job_o
);

  logic [1:0]                    fill_q, fill_d;
  logic [b64d_pkg::StoreW-1:0]   store_q, store_d;
  logic                          halted_q, halted_d;

  logic                          accept;
  logic                          code_ok;
  logic [b64d_pkg::SextetW-1:0]  sext;
  logic                          take_char;
  logic                          full_group;
  logic [1:0]                    fill_a;
  logic [b64d_pkg::StoreW-1:0]   store_a;
  logic                          halted_a;

  // Returns {valid, value} for one base64 character
  function automatic logic [b64d_pkg::SextetW:0] classify(input logic [7:0] c);
    logic [7:0] diff;
    logic [b64d_pkg::SextetW:0] res;
    diff = 8'h00;
    res  = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      diff = c - 8'h41;
      res  = {1'b1, diff[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      diff = c - 8'h61 + 8'd26;
      res  = {1'b1, diff[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30 + 8'd52;
      res  = {1'b1, diff[5:0]};
    end else if (c == 8'h2B) begin
      res = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      res = {1'b1, 6'd63};
    end
    return res;
  endfunction

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign {code_ok, sext} = classify(char_code_i);

  always_comb begin
    take_char  = !halted_q && code_ok;
    full_group = take_char && (fill_q == 2'd3);
    fill_a     = fill_q;
    store_a    = store_q;
    halted_a   = halted_q || (!halted_q && !code_ok);
    job_o      = '0;

    if (full_group) begin
      fill_a         = 2'd0;
      store_a        = '0;
      job_o.word     = {store_q, sext};
      job_o.nbytes   = b64d_pkg::NBytesThree;
    end else if (take_char) begin
      fill_a  = fill_q + 2'd1;
      store_a = {store_q[b64d_pkg::StoreW-b64d_pkg::SextetW-1:0], sext};
    end

    job_o.last = end_of_text_i;
    if (end_of_text_i && !full_group) begin
      unique case (fill_a)
        2'd2: begin
          job_o.word   = {store_a[11:0], 12'h000};
          job_o.nbytes = b64d_pkg::NBytesOne;
        end
        2'd3: begin
          job_o.word   = {store_a, 6'h00};
          job_o.nbytes = b64d_pkg::NBytesTwo;
        end
        default: begin
          // nothing left to release: close the text with an empty marker
          job_o.word    = '0;
          job_o.nbytes  = b64d_pkg::NBytesOne;
          job_o.no_data = 1'b1;
        end
      endcase
    end

    push_o = accept && (full_group || end_of_text_i);

    fill_d   = fill_q;
    store_d  = store_q;
    halted_d = halted_q;
    if (accept) begin
      if (end_of_text_i) begin
        fill_d   = 2'd0;
        store_d  = '0;
        halted_d = 1'b0;
      end else begin
        fill_d   = fill_a;
        store_d  = store_a;
        halted_d = halted_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= 2'd0;
      store_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      store_q  <= store_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ===== sv/b64d_queue.sv =====
// Job queue between the decoder front and back ends.
// Small circular buffer of b64d_pkg::job_t entries with a fill count.
`timescale 1ns / 1ps

module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64d_pkg::job_t  push_job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output b64d_pkg::job_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_pkg::job_t   entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/b64d_back.sv =====
// Back end: splits queued jobs into single output words, one per cycle while out_stall_i is low.
// Holds the output register; uses b64d_pkg::job_t.
`timescale 1ns / 1ps

module b64d_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  b64d_pkg::job_t  head_i,
  output logic            pop_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [7:0]      data_byte_o,
  output logic            no_data_o,
  output logic            last_of_text_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       no_data_q, no_data_d;
  logic       last_q, last_d;

  logic       load;
  logic       take;
  logic       final_byte;
  logic [7:0] sel_byte;

  assign load       = !valid_q || !out_stall_i;
  assign take       = load && !empty_i;
  assign final_byte = (idx_q == head_i.nbytes - 2'd1);
  assign pop_o      = take && final_byte;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = head_i.word[23:16];
      2'd1:    sel_byte = head_i.word[15:8];
      default: sel_byte = head_i.word[7:0];
    endcase
  end

  always_comb begin
    idx_d     = idx_q;
    valid_d   = valid_q;
    byte_d    = byte_q;
    no_data_d = no_data_q;
    last_d    = last_q;
    if (load) begin
      valid_d = !empty_i;
    end
    if (take) begin
      byte_d    = sel_byte;
      no_data_d = head_i.no_data;
      last_d    = head_i.last && final_byte;
      // advance within the job, or move on to the next one
      idx_d     = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    no_data_q <= no_data_d;
    last_q    <= last_d;
  end

  assign out_valid_o    = valid_q;
  assign data_byte_o    = byte_q;
  assign no_data_o      = no_data_q;
  assign last_of_text_o = last_q;

endmodule

// ===== sv/base64_decoder_unit.sv =====
// Top level of the base64 decoder: front end, job queue and back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+-------------------------------------
//   input   | in_valid_i  | in_stall_o   | char_code_i, end_of_text_i
//   output  | out_valid_o | out_stall_i  | data_byte_o, no_data_o, last_of_text_o
//
// One character is taken every cycle while the job queue has room.
// The back end delivers one word per cycle while out_stall_i is low, so a full group of
// four characters yields three output words; the queue (QueueDepth jobs) absorbs the bursts.
// A released word passes through the queue entry and then the back-end output register.
// Reset clears the group state, the queue pointers and the output valid.
`timescale 1ns / 1ps

module base64_decoder_unit #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       no_data_o,
  output logic       last_of_text_o
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  b64d_pkg::job_t push_job;
  b64d_pkg::job_t head_job;

  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .queue_full_i  (full),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .job_o         (push_job)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  b64d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head_job),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .data_byte_o    (data_byte_o),
    .no_data_o      (no_data_o),
    .last_of_text_o (last_of_text_o)
  );

endmodule

// ===== sv/b64d_checker.sv =====
// Port-level checks for base64_decoder_unit, attached with a bind.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module b64d_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       end_of_text_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] data_byte_o,
  input logic       no_data_o,
  input logic       last_of_text_o
);

  logic [7:0] open_texts_q, open_texts_d;
  logic       eot_in;
  logic       last_out;

  assign eot_in   = in_valid_i && !in_stall_o && end_of_text_i;
  assign last_out = out_valid_o && !out_stall_i && last_of_text_o;

  // count texts closed on the input side but not yet on the output side
  always_comb begin
    open_texts_d = open_texts_q;
    if (eot_in && !last_out) begin
      open_texts_d = open_texts_q + 8'd1;
    end else if (last_out && !eot_in) begin
      open_texts_d = open_texts_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_texts_q <= 8'd0;
    end else begin
      open_texts_q <= open_texts_d;
    end
  end

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(no_data_o) && $stable(last_of_text_o))
    else $error("stalled output word changed");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_data_o |-> data_byte_o == 8'h00 && last_of_text_o)
    else $error("empty marker without zero byte or last mark");

  a_last_has_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_out |-> open_texts_q != 8'd0)
    else $error("text closed on output before its end was accepted");

endmodule

bind base64_decoder_unit b64d_props u_b64d_props (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .end_of_text_i  (end_of_text_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .data_byte_o    (data_byte_o),
  .no_data_o      (no_data_o),
  .last_of_text_o (last_of_text_o)
);
